// ----- hdl/sis_pkg.sv -----
// ----------------------------------------------------------------------------
// sis_pkg
// Shared types and codes of the sorted integer set unit.
// ----------------------------------------------------------------------------
package sis_pkg;

    // operation selector carried in the input tuser
    typedef enum logic [1:0] {
        FUNC_INSERT   = 2'd0,
        FUNC_REMOVE   = 2'd1,
        FUNC_CONTAINS = 2'd2,
        FUNC_GET      = 2'd3
    } t_func;

    // result status carried in the output tuser
    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } t_status;

    // storage width class
    typedef enum logic [1:0] {
        CLASS_16 = 2'd0,
        CLASS_32 = 2'd1,
        CLASS_64 = 2'd2
    } t_class;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic        compare;
        logic        insert;
        logic        remove;
        logic [63:0] value;
    } t_cell_ctl;

    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

    // smallest class that holds a signed value
    function automatic t_class class_of(input logic [63:0] v);
        t_class c;
        if (&v[63:15] || ~|v[63:15]) begin
            c = CLASS_16;
        end else if (&v[63:31] || ~|v[63:31]) begin
            c = CLASS_32;
        end else begin
            c = CLASS_64;
        end
        return c;
    endfunction

endpackage

// ----- hdl/sis_cell.sv -----
// ----------------------------------------------------------------------------
// sis_cell
// One entry of the sorted chain: compares against the broadcast value and
// takes data from a neighbor on insert or remove.
// ----------------------------------------------------------------------------
module sis_cell #(
    parameter int IDX  = 0,
    parameter int CNTW = 9,
    parameter int IDXW = 8
) (
    input  logic                i_clk,
    input  sis_pkg::t_cell_ctl  i_ctl,
    input  logic [CNTW-1:0]     i_count,
    input  logic [IDXW-1:0]     i_index,
    input  logic                i_prev_lt,
    input  logic [63:0]         i_prev_data,
    input  logic [63:0]         i_next_data,
    output logic                o_lt,
    output logic                o_eq,
    output logic                o_bnd,
    output logic [63:0]         o_data,
    output logic [63:0]         o_get
);
    import sis_pkg::*;

    localparam logic [CNTW-1:0] POS_C = CNTW'(IDX);
    localparam logic [IDXW-1:0] POS_I = IDXW'(IDX);

    logic [63:0] r_data;
    logic        r_lt;
    logic        r_eq;
    logic        w_valid;

    assign w_valid = POS_C < i_count;

    // compare step: entry below value, entry equal to value
    always_ff @(posedge i_clk) begin
        if (i_ctl.compare) begin
            r_lt <= w_valid && ((r_data ^ SIGN_BIT) < (i_ctl.value ^ SIGN_BIT));
            r_eq <= w_valid && (r_data == i_ctl.value);
        end
    end

    // update step: shift up behind the insert point, shift down from the hole
    always_ff @(posedge i_clk) begin
        if (i_ctl.insert) begin
            if (!r_lt && i_prev_lt) begin
                r_data <= i_ctl.value;
            end else if (!i_prev_lt) begin
                r_data <= i_prev_data;
            end
        end else if (i_ctl.remove) begin
            if (!r_lt) begin
                r_data <= i_next_data;
            end
        end
    end

    assign o_lt   = r_lt;
    assign o_eq   = r_eq;
    assign o_bnd  = !r_lt && i_prev_lt;
    assign o_data = r_data;
    assign o_get  = (i_index == POS_I) ? r_data : 64'd0;

endmodule

// ----- hdl/sorted_integer_set_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_integer_set_unit
// Set of distinct signed 64-bit integers held in ascending order in a chain
// of compare-and-shift cells, with insert, remove, contains and get.
// ----------------------------------------------------------------------------
// Each item passes through three steps: the accept in idle, a compare step
// in which every cell of the chain compares its entry with the value at
// once, and an update step, held until the output slot is free, in
// which the lower-bound position is encoded, the cells shift by one place
// toward or away from it and the result is written to the output register.
// A new item is taken as soon as the unit is back in idle, even while the
// previous result still waits on the output side. The entries need no
// clearing after reset: only entries below the count are ever read.
module sorted_integer_set_unit #(
    parameter int CAPACITY = 256
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // input item
    input  logic                                      i_s_tvalid,
    output logic                                      o_s_tready,
    // value [63:0], index [63+IDXW:64], zero fill
    input  logic [((64+$clog2(CAPACITY)+7)/8)*8-1:0]  i_s_tdata,
    // func [1:0]
    input  logic [1:0]                                i_s_tuser,
    // result item
    output logic                                      o_m_tvalid,
    input  logic                                      i_m_tready,
    // found, position, element, count, width_class from bit 0 up, zero fill
    output logic [((2*$clog2(CAPACITY+1)+67+7)/8)*8-1:0] o_m_tdata,
    // status [1:0]
    output logic [1:0]                                o_m_tuser
);
    import sis_pkg::*;

    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int IDXW = $clog2(CAPACITY);
    localparam int OW   = 2 * CNTW + 67;
    localparam int OTW  = ((OW + 7) / 8) * 8;
    localparam logic [CNTW-1:0] CAP_C = CNTW'(CAPACITY);

    t_state          r_state, n_state;
    t_func           r_func;
    logic [63:0]     r_value;
    logic [IDXW-1:0] r_index;
    logic [CNTW-1:0] r_count;
    t_class          r_class;
    logic            r_out_valid;
    logic [OTW-1:0]  r_out_data;
    t_status         r_out_status;

    t_cell_ctl           w_ctl;
    logic [CAPACITY-1:0] w_lt, w_eq, w_bnd;
    logic [63:0]         w_data [CAPACITY];
    logic [63:0]         w_get  [CAPACITY];

    logic            w_slot_free;
    logic            w_accept;
    logic            w_update;
    logic            w_found;
    logic [CNTW-1:0] w_pos;
    logic [63:0]     w_elem;
    logic            w_full;
    logic            w_do_ins;
    logic            w_do_rem;
    t_class          w_new_class;

    logic            n_found;
    logic [CNTW-1:0] n_pos;
    logic [63:0]     n_elem;
    logic [CNTW-1:0] n_count;
    t_class          n_class;
    t_status         n_status;

    assign w_slot_free = !r_out_valid || i_m_tready;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_update    = (r_state == ST_UPD) && w_slot_free;

    // chain of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        sis_cell #(
            .IDX  (g),
            .CNTW (CNTW),
            .IDXW (IDXW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_index     (r_index),
            .i_prev_lt   ((g == 0) ? 1'b1 : w_lt[(g == 0) ? 0 : g - 1]),
            .i_prev_data (w_data[(g == 0) ? 0 : g - 1]),
            .i_next_data (w_data[(g == CAPACITY - 1) ? g : g + 1]),
            .o_lt        (w_lt[g]),
            .o_eq        (w_eq[g]),
            .o_bnd       (w_bnd[g]),
            .o_data      (w_data[g]),
            .o_get       (w_get[g])
        );
    end

    // position encode from the one-hot boundary, get read by and-or
    always_comb begin
        w_pos  = '0;
        w_elem = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_bnd[i]) begin
                w_pos = w_pos | CNTW'(i);
            end
            w_elem = w_elem | w_get[i];
        end
        if (w_lt[CAPACITY-1]) begin
            w_pos = CAP_C;
        end
    end

    assign w_found     = |w_eq;
    assign w_full      = (r_count == CAP_C);
    assign w_do_ins    = w_update && (r_func == FUNC_INSERT) && !w_found && !w_full;
    assign w_do_rem    = w_update && (r_func == FUNC_REMOVE) && w_found;
    assign w_new_class = class_of(r_value);

    // broadcast control
    always_comb begin
        w_ctl.compare = (r_state == ST_CMP);
        w_ctl.insert  = w_do_ins;
        w_ctl.remove  = w_do_rem;
        w_ctl.value   = r_value;
    end

    // result and next set state
    always_comb begin
        n_found  = w_found;
        n_pos    = w_pos;
        n_elem   = '0;
        n_count  = r_count;
        n_class  = r_class;
        n_status = STATUS_DONE;
        case (r_func)
            FUNC_GET: begin
                n_pos = CNTW'(r_index);
                if (CNTW'(r_index) < r_count) begin
                    n_found = 1'b1;
                    n_elem  = w_elem;
                end else begin
                    n_found  = 1'b0;
                    n_status = STATUS_RANGE;
                end
            end
            FUNC_INSERT: begin
                if (!w_found) begin
                    if (w_full) begin
                        n_status = STATUS_FULL;
                    end else begin
                        n_count = r_count + 1'b1;
                        if (w_new_class > r_class) begin
                            n_class = w_new_class;
                        end
                    end
                end
            end
            FUNC_REMOVE: begin
                if (w_found) begin
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // operation capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func  <= t_func'(i_s_tuser);
            r_value <= i_s_tdata[63:0];
            r_index <= i_s_tdata[64 +: IDXW];
        end
    end

    // set count and width class
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_class <= CLASS_16;
        end else if (w_update) begin
            r_count <= n_count;
            r_class <= n_class;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_update) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_out_data   <= OTW'({n_class, n_count, n_elem, n_pos, n_found});
            r_out_status <= n_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

endmodule
